/* rtl/core/edfts_pkg.sv */
// Shared types, codes and defaults for the EDF task queue scheduler.
// No dependencies; imported by edfts_cell, edf_task_queue_scheduler_core and the verif files.
package edfts_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned EVENT_W  = 8;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned CFG_AW   = 3;

  // Defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [EVENT_W-1:0] DISPATCH_AFTER_RESET = 8'd3;

  // Register word index
  localparam logic REG_DISPATCH_AFTER = 1'b0;

  // Action codes; any other code is a plain tick
  localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd2;

  // Cell commands
  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CMD_HOLD   = 2'd0;
  localparam cell_cmd_t CMD_INSERT = 2'd1;
  localparam cell_cmd_t CMD_POP    = 2'd2;

  // Per-cell control from the sequencer and the left neighbor
  typedef struct packed {
    cell_cmd_t cmd;
    logic      occupied;
    logic      left_gt;
  } cell_ctl_t;

endpackage

/* rtl/core/edf_task_queue_scheduler_core.sv */
// Top level of the EDF task queue scheduler: sequencer, counters, APB
// register and a row of edfts_cell slots. Depends on edfts_pkg, edfts_cell.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  input    | start / busy     | in_action, in_task_id, in_deadline, in_now
//  result   | out_strobe       | out_dispatch_*, out_preempt_*, out_done_*,
//           |                  | out_late_*, out_dropped, out_active_count,
//           |                  | out_completed_total, out_overdue_total
//  config   | psel/penable/... | dispatch_after_events at byte address 0
//
// For an item, the accept edge inserts or pops in the cell row, the next
// edge does the overdue check of the head and the dispatch, and the result
// shows with out_strobe in the cycle after that. No new item is taken while
// busy. busy is high for the one resolve cycle. Reset is synchronous,
// active low, and empties the queue at once. The receiver cannot stall.
module edf_task_queue_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = edfts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [edfts_pkg::ACTION_W-1:0] in_action,
  input  logic [edfts_pkg::ID_W-1:0]    in_task_id,
  input  logic [edfts_pkg::TIME_W-1:0]  in_deadline,
  input  logic [edfts_pkg::TIME_W-1:0]  in_now,
  // result channel
  output logic                          out_strobe,
  output logic                          out_dispatch_valid,
  output logic [edfts_pkg::ID_W-1:0]    out_dispatch_id,
  output logic                          out_preempt_valid,
  output logic [edfts_pkg::ID_W-1:0]    out_preempt_id,
  output logic                          out_done_valid,
  output logic [edfts_pkg::ID_W-1:0]    out_done_id,
  output logic                          out_late_valid,
  output logic [edfts_pkg::ID_W-1:0]    out_late_id,
  output logic                          out_dropped,
  output logic [edfts_pkg::COUNT_W-1:0] out_active_count,
  output logic [edfts_pkg::TOTAL_W-1:0] out_completed_total,
  output logic [edfts_pkg::TOTAL_W-1:0] out_overdue_total,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edfts_pkg::CFG_AW-1:0]  paddr,
  input  logic [edfts_pkg::CFG_DW-1:0]  pwdata,
  output logic [edfts_pkg::CFG_DW-1:0]  prdata,
  output logic                          pready
);
  import edfts_pkg::*;

  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE    = 1'b0;
  localparam logic ST_RESOLVE = 1'b1;

  // Sequencer and control state
  logic              state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              run_r, run_nxt;
  logic [EVENT_W-1:0] ev_r, ev_nxt;
  logic [TOTAL_W-1:0] comp_r, comp_nxt;
  logic [TOTAL_W-1:0] over_r, over_nxt;
  logic [EVENT_W-1:0] dae_r;
  logic              strobe_r;

  // Per-item holding registers
  logic [TIME_W-1:0] now_r;
  logic              pre_v_r, done_v_r, drop_r;
  logic [ID_W-1:0]   pre_id_r, done_id_r;

  // Result registers
  logic              disp_v_r, late_v_r, o_pre_v_r, o_done_v_r, o_drop_r;
  logic [ID_W-1:0]   disp_id_r, late_id_r, o_pre_id_r, o_done_id_r;

  // Cell row
  cell_cmd_t         row_cmd;
  logic [ID_W-1:0]   cid [QUEUE_DEPTH];
  logic [TIME_W-1:0] cdl [QUEUE_DEPTH];
  logic              cgt [QUEUE_DEPTH];

  logic accept, is_rel, is_cmp, full, hit, ins, late, disp;
  logic run_after;
  logic [FW-1:0] fill_after;
  logic [FW+COUNT_W-1:0] fill_ext;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_RESOLVE);
  assign is_rel = (in_action == ACT_RELEASE);
  assign is_cmp = (in_action == ACT_COMPLETE);
  assign full   = (fill_r == FW'(QUEUE_DEPTH));
  assign hit    = (fill_r != '0) && (cid[0] == in_task_id);
  assign ins    = is_rel && !full;

  // Overdue check and dispatch on the resolve cycle
  assign late       = (fill_r != '0) && (now_r > cdl[0]);
  assign fill_after = late ? fill_r - FW'(1) : fill_r;
  assign run_after  = late ? 1'b0 : run_r;
  assign disp       = (ev_r >= dae_r) && (fill_after != '0) && !run_after;

  // Row command
  always_comb begin
    row_cmd = CMD_HOLD;
    if (state_r == ST_RESOLVE) begin
      if (late) row_cmd = CMD_POP;
    end else if (accept) begin
      if (ins) row_cmd = CMD_INSERT;
      else if (is_cmp && hit) row_cmd = CMD_POP;
    end
  end

  // Build the cell row
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cell_ctl_t         ctl;
    logic              lgt;
    logic [ID_W-1:0]   lid, rid;
    logic [TIME_W-1:0] ldl, rdl;
    if (g == 0) begin : g_first
      assign lid = '0;
      assign ldl = '0;
      assign lgt = 1'b0;
    end else begin : g_mid
      assign lid = cid[g-1];
      assign ldl = cdl[g-1];
      assign lgt = cgt[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign rid = cid[g];
      assign rdl = cdl[g];
    end else begin : g_inner
      assign rid = cid[g+1];
      assign rdl = cdl[g+1];
    end
    assign ctl = '{cmd: row_cmd, occupied: (FW'(g) < fill_r), left_gt: lgt};

    edfts_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_id   (in_task_id),
      .new_dl   (in_deadline),
      .left_id  (lid),
      .left_dl  (ldl),
      .right_id (rid),
      .right_dl (rdl),
      .id       (cid[g]),
      .dl       (cdl[g]),
      .gt       (cgt[g])
    );
  end

  // Next control state
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    run_nxt   = run_r;
    ev_nxt    = ev_r;
    comp_nxt  = comp_r;
    over_nxt  = over_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESOLVE;
          if ((is_rel || is_cmp) && (ev_r != '1)) ev_nxt = ev_r + EVENT_W'(1);
          if (ins) begin
            fill_nxt = fill_r + FW'(1);
            if (cgt[0] && (fill_r != '0)) run_nxt = 1'b0;
          end else if (is_cmp && hit) begin
            fill_nxt = fill_r - FW'(1);
            run_nxt  = 1'b0;
            if (comp_r != '1) comp_nxt = comp_r + TOTAL_W'(1);
          end
        end
      end
      ST_RESOLVE: begin
        state_nxt = ST_IDLE;
        fill_nxt  = fill_after;
        run_nxt   = run_after || disp;
        if (late && (over_r != '1)) over_nxt = over_r + TOTAL_W'(1);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      run_r    <= 1'b0;
      ev_r     <= '0;
      comp_r   <= '0;
      over_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      run_r    <= run_nxt;
      ev_r     <= ev_nxt;
      comp_r   <= comp_nxt;
      over_r   <= over_nxt;
      strobe_r <= (state_r == ST_RESOLVE);
    end
  end

  // Capture the item's first-phase outcome
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r     <= in_now;
      drop_r    <= is_rel && full;
      pre_v_r   <= ins && cgt[0] && (fill_r != '0) && run_r;
      pre_id_r  <= cid[0];
      done_v_r  <= is_cmp && hit;
      done_id_r <= cid[0];
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (state_r == ST_RESOLVE) begin
      disp_v_r    <= disp;
      disp_id_r   <= disp ? (late ? cid[1] : cid[0]) : '0;
      late_v_r    <= late;
      late_id_r   <= late ? cid[0] : '0;
      o_pre_v_r   <= pre_v_r;
      o_pre_id_r  <= pre_v_r ? pre_id_r : '0;
      o_done_v_r  <= done_v_r;
      o_done_id_r <= done_v_r ? done_id_r : '0;
      o_drop_r    <= drop_r;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dae_r <= DISPATCH_AFTER_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DISPATCH_AFTER)) begin
      dae_r <= pwdata[EVENT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DISPATCH_AFTER) ? CFG_DW'(dae_r) : '0;

  assign fill_ext = {{COUNT_W{1'b0}}, fill_r};

  assign out_strobe          = strobe_r;
  assign out_dispatch_valid  = disp_v_r;
  assign out_dispatch_id     = disp_id_r;
  assign out_preempt_valid   = o_pre_v_r;
  assign out_preempt_id      = o_pre_id_r;
  assign out_done_valid      = o_done_v_r;
  assign out_done_id         = o_done_id_r;
  assign out_late_valid      = late_v_r;
  assign out_late_id         = late_id_r;
  assign out_dropped         = o_drop_r;
  assign out_active_count    = fill_ext[COUNT_W-1:0];
  assign out_completed_total = comp_r;
  assign out_overdue_total   = over_r;

endmodule

/* rtl/core/edfts_cell.sv */
// One slot of the sorted queue: holds an id and a deadline and trades them
// with its neighbors. Depends on edfts_pkg.
module edfts_cell (
  input  logic                         clk,
  input  edfts_pkg::cell_ctl_t         ctl,
  input  logic [edfts_pkg::ID_W-1:0]   new_id,
  input  logic [edfts_pkg::TIME_W-1:0] new_dl,
  input  logic [edfts_pkg::ID_W-1:0]   left_id,
  input  logic [edfts_pkg::TIME_W-1:0] left_dl,
  input  logic [edfts_pkg::ID_W-1:0]   right_id,
  input  logic [edfts_pkg::TIME_W-1:0] right_dl,
  output logic [edfts_pkg::ID_W-1:0]   id,
  output logic [edfts_pkg::TIME_W-1:0] dl,
  output logic                         gt
);
  import edfts_pkg::*;

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TIME_W-1:0] dl_r, dl_nxt;

  // The new item goes before this slot if the slot is empty or later
  assign gt = !ctl.occupied || (dl_r > new_dl);

  // Pick insert, shift or pop
  always_comb begin
    id_nxt = id_r;
    dl_nxt = dl_r;
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (ctl.left_gt) begin
          id_nxt = left_id;
          dl_nxt = left_dl;
        end else if (gt) begin
          id_nxt = new_id;
          dl_nxt = new_dl;
        end
      end
      CMD_POP: begin
        id_nxt = right_id;
        dl_nxt = right_dl;
      end
      default: begin
        id_nxt = id_r;
        dl_nxt = dl_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign id = id_r;
  assign dl = dl_r;

endmodule

/* verif/edfts_sched_checker.sv */
// Result checker for the EDF task queue scheduler: watches the item, result
// and register channels, predicts every result and compares field by field.
// Depends on edfts_pkg; instantiated by edf_task_queue_scheduler_core_test.
module edfts_sched_checker
  import edfts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic [TIME_W-1:0]   in_deadline,
  input  logic [TIME_W-1:0]   in_now,
  input  logic                out_strobe,
  input  logic                out_dispatch_valid,
  input  logic [ID_W-1:0]     out_dispatch_id,
  input  logic                out_preempt_valid,
  input  logic [ID_W-1:0]     out_preempt_id,
  input  logic                out_done_valid,
  input  logic [ID_W-1:0]     out_done_id,
  input  logic                out_late_valid,
  input  logic [ID_W-1:0]     out_late_id,
  input  logic                out_dropped,
  input  logic [COUNT_W-1:0]  out_active_count,
  input  logic [TOTAL_W-1:0]  out_completed_total,
  input  logic [TOTAL_W-1:0]  out_overdue_total,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  input  logic [CFG_DW-1:0]   prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending,
  output int                  fill_level,
  output logic [ID_W-1:0]     head_id,
  output int                  n_items,
  output int                  n_dispatch,
  output int                  n_preempt,
  output int                  n_done,
  output int                  n_late,
  output int                  n_drop
);

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [CFG_AW-1:0] DISPATCH_ADDR = {REG_DISPATCH_AFTER, 2'b00};

  typedef struct packed {
    logic               dispatch_valid;
    logic [ID_W-1:0]    dispatch_id;
    logic               preempt_valid;
    logic [ID_W-1:0]    preempt_id;
    logic               done_valid;
    logic [ID_W-1:0]    done_id;
    logic               late_valid;
    logic [ID_W-1:0]    late_id;
    logic               dropped;
    logic [COUNT_W-1:0] active_count;
    logic [TOTAL_W-1:0] completed_total;
    logic [TOTAL_W-1:0] overdue_total;
  } sched_result_t;

  // Predicted scheduler state, kept sorted by deadline
  logic [ID_W-1:0]    slot_id [DEPTH];
  logic [TIME_W-1:0]  slot_dl [DEPTH];
  int unsigned        slot_fill;
  bit                 head_busy;
  logic [EVENT_W-1:0] event_seen;
  logic [TOTAL_W-1:0] completed_sum;
  logic [TOTAL_W-1:0] overdue_sum;
  logic [EVENT_W-1:0] dispatch_thresh;

  sched_result_t pending_results[$];
  sched_result_t want;
  sched_result_t got;
  int            result_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    fill_level = 0;
    head_id    = '0;
    n_items    = 0;
    n_dispatch = 0;
    n_preempt  = 0;
    n_done     = 0;
    n_late     = 0;
    n_drop     = 0;
    result_idx = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted)
      report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                       result_idx, name, seen, wanted));
  endtask

  // Drop the head and shift the rest up one slot
  function automatic void retire_head();
    int unsigned i;
    for (i = 1; i < slot_fill && i < DEPTH; i++) begin
      slot_id[i-1] = slot_id[i];
      slot_dl[i-1] = slot_dl[i];
    end
    if (slot_fill > 0) slot_fill--;
    head_busy = 1'b0;
  endfunction

  // Apply one item to the predicted queue and return the result it causes
  function automatic sched_result_t schedule_item(input logic [ACTION_W-1:0] act,
                                                  input logic [ID_W-1:0] tid,
                                                  input logic [TIME_W-1:0] dl,
                                                  input logic [TIME_W-1:0] t_now);
    sched_result_t r;
    int unsigned   pos;
    int unsigned   i;
    logic [ID_W-1:0] old_head;
    r = '0;
    if (act == ACT_RELEASE) begin
      if (event_seen != '1) event_seen++;
      if (slot_fill >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        // ties go behind entries already queued
        pos = 0;
        while (pos < slot_fill && slot_dl[pos] <= dl) pos++;
        old_head = slot_id[0];
        for (i = slot_fill; i > pos; i--) begin
          slot_id[i] = slot_id[i-1];
          slot_dl[i] = slot_dl[i-1];
        end
        if (pos == 0 && slot_fill > 0 && head_busy) begin
          r.preempt_valid = 1'b1;
          r.preempt_id    = old_head;
          head_busy       = 1'b0;
        end
        slot_id[pos] = tid;
        slot_dl[pos] = dl;
        slot_fill++;
      end
    end else if (act == ACT_COMPLETE) begin
      if (event_seen != '1) event_seen++;
      if (slot_fill > 0 && slot_id[0] == tid) begin
        r.done_valid = 1'b1;
        r.done_id    = slot_id[0];
        if (completed_sum != '1) completed_sum++;
        retire_head();
      end
    end
    // only the head is checked for a missed deadline
    if (slot_fill > 0 && t_now > slot_dl[0]) begin
      r.late_valid = 1'b1;
      r.late_id    = slot_id[0];
      if (overdue_sum != '1) overdue_sum++;
      retire_head();
    end
    if (event_seen >= dispatch_thresh && slot_fill > 0 && !head_busy) begin
      head_busy        = 1'b1;
      r.dispatch_valid = 1'b1;
      r.dispatch_id    = slot_id[0];
    end
    r.active_count    = slot_fill[COUNT_W-1:0];
    r.completed_total = completed_sum;
    r.overdue_total   = overdue_sum;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_fill       = 0;
      head_busy       = 1'b0;
      event_seen      = '0;
      completed_sum   = '0;
      overdue_sum     = '0;
      dispatch_thresh = DISPATCH_AFTER_RESET;
      pending_results.delete();
      for (int i = 0; i < DEPTH; i++) begin
        slot_id[i] = '0;
        slot_dl[i] = '0;
      end
    end else begin
      // register writes update the threshold, reads must return it
      if (psel && penable && pready && paddr == DISPATCH_ADDR) begin
        if (pwrite)
          dispatch_thresh = pwdata[EVENT_W-1:0];
        else if (prdata !== {{(CFG_DW-EVENT_W){1'b0}}, dispatch_thresh})
          report($sformatf("register read 0x%0h, want 0x%0h", prdata, dispatch_thresh));
      end
      // compare a result with the oldest expectation
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d arrived with no item waiting", result_idx));
        end else begin
          want = pending_results.pop_front();
          got  = '{out_dispatch_valid, out_dispatch_id, out_preempt_valid, out_preempt_id,
                   out_done_valid, out_done_id, out_late_valid, out_late_id, out_dropped,
                   out_active_count, out_completed_total, out_overdue_total};
          check_field("dispatch_valid", got.dispatch_valid, want.dispatch_valid);
          check_field("dispatch_id", got.dispatch_id, want.dispatch_id);
          check_field("preempt_valid", got.preempt_valid, want.preempt_valid);
          check_field("preempt_id", got.preempt_id, want.preempt_id);
          check_field("done_valid", got.done_valid, want.done_valid);
          check_field("done_id", got.done_id, want.done_id);
          check_field("late_valid", got.late_valid, want.late_valid);
          check_field("late_id", got.late_id, want.late_id);
          check_field("dropped", got.dropped, want.dropped);
          check_field("active_count", got.active_count, want.active_count);
          check_field("completed_total", got.completed_total, want.completed_total);
          check_field("overdue_total", got.overdue_total, want.overdue_total);
        end
        result_idx++;
      end
      // predict each accepted item
      if (start && !busy) begin
        want = schedule_item(in_action, in_task_id, in_deadline, in_now);
        pending_results.push_back(want);
        n_items++;
        n_dispatch += want.dispatch_valid;
        n_preempt  += want.preempt_valid;
        n_done     += want.done_valid;
        n_late     += want.late_valid;
        n_drop     += want.dropped;
      end
    end
    pending    = pending_results.size();
    fill_level = slot_fill;
    head_id    = slot_id[0];
  end

endmodule

/* verif/edf_task_queue_scheduler_core_test.sv */
// Testbench top for the EDF task queue scheduler: clock, reset, item and
// register stimulus, and the verdict. Depends on edfts_pkg, the scheduler
// core and edfts_sched_checker, which does all prediction and comparison.
module edf_task_queue_scheduler_core_test;
  import edfts_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;  // unused code, acts as a tick
  localparam logic [CFG_AW-1:0] DISPATCH_ADDR = {REG_DISPATCH_AFTER, 2'b00};
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 230;

  logic clk;
  logic rst_n = 1'b0;

  logic                start       = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] in_action   = ACT_TICK;
  logic [ID_W-1:0]     in_task_id  = '0;
  logic [TIME_W-1:0]   in_deadline = '0;
  logic [TIME_W-1:0]   in_now      = '0;

  logic                out_strobe;
  logic                out_dispatch_valid;
  logic [ID_W-1:0]     out_dispatch_id;
  logic                out_preempt_valid;
  logic [ID_W-1:0]     out_preempt_id;
  logic                out_done_valid;
  logic [ID_W-1:0]     out_done_id;
  logic                out_late_valid;
  logic [ID_W-1:0]     out_late_id;
  logic                out_dropped;
  logic [COUNT_W-1:0]  out_active_count;
  logic [TOTAL_W-1:0]  out_completed_total;
  logic [TOTAL_W-1:0]  out_overdue_total;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CFG_AW-1:0]   paddr   = '0;
  logic [CFG_DW-1:0]   pwdata  = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  int              fail_count;
  int              pending;
  int              fill_level;
  logic [ID_W-1:0] head_id;
  int              n_items, n_dispatch, n_preempt, n_done, n_late, n_drop;

  int                cycle_count = 0;
  logic [TIME_W-1:0] now_t       = '0;
  int                burst_left  = 0;

  edf_task_queue_scheduler_core dut (.*);

  edfts_sched_checker sched_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item, hold it until accepted, then, unless calm, maybe pause before the next one
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] tid,
                           input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] t_now,
                           input bit calm);
    @(posedge clk);
    in_action   <= act;
    in_task_id  <= tid;
    in_deadline <= dl;
    in_now      <= t_now;
    start       <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (!calm && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input bit wr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= DISPATCH_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off new items until every expected result has come back
  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed traffic with advancing time, plus noise and fill bursts
  task automatic pick_item(output logic [ACTION_W-1:0] act, output logic [ID_W-1:0] tid,
                           output logic [TIME_W-1:0] dl, output logic [TIME_W-1:0] t_now);
    int roll;
    int sub;
    roll  = $urandom_range(0, 99);
    tid   = ID_W'($urandom_range(0, 255));
    dl    = now_t + $urandom_range(0, 60);
    t_now = now_t;
    act   = ACT_TICK;
    if (burst_left > 0) begin
      // long deadlines so the queue fills up and releases get dropped
      burst_left--;
      now_t = now_t + $urandom_range(0, 1);
      t_now = now_t;
      act   = ACT_RELEASE;
      dl    = now_t + 2000 + 8 * $urandom_range(0, 6);
    end else if (roll < 15) begin
      act = ACTION_W'($urandom_range(0, 3));
      dl  = $urandom;
      if ($urandom_range(0, 1)) t_now = $urandom;
    end else begin
      if (roll < 17) burst_left = 20;
      now_t = now_t + $urandom_range(0, 3);
      t_now = now_t;
      sub   = $urandom_range(0, 99);
      if (sub < 45) begin
        act = ACT_RELEASE;
        dl  = now_t + 4 * $urandom_range(0, 12);
      end else if (sub < 80) begin
        act = ACT_COMPLETE;
        if ($urandom_range(0, 99) < 85 && fill_level > 0) tid = head_id;
      end else begin
        act = $urandom_range(0, 1) ? ACT_TICK : ACT_SPARE;
      end
    end
  endtask

  initial begin
    logic [ACTION_W-1:0] act;
    logic [ID_W-1:0]     tid;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   t_now;
    logic [EVENT_W-1:0]  cfg_plan [5];
    int                  k;

    cfg_plan = '{8'd255, 8'd0, 8'($urandom_range(1, 254)), 8'd1, 8'd3};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    apb_access(1'b0, '0);

    // Directed: empty queue, completion before dispatch, ties, preemption,
    // immediate overdue, mismatched completion, spare code, time extremes
    send_item(ACT_TICK,     8'h00, 32'd0,        32'd0,        1'b1);
    send_item(ACT_COMPLETE, 8'h05, 32'd0,        32'd0,        1'b1);
    send_item(ACT_RELEASE,  8'h10, 32'd100,      32'd0,        1'b1);
    send_item(ACT_COMPLETE, 8'h10, 32'd0,        32'd0,        1'b1);
    send_item(ACT_RELEASE,  8'h20, 32'd100,      32'd0,        1'b1);
    send_item(ACT_RELEASE,  8'h21, 32'd100,      32'd0,        1'b1);
    send_item(ACT_RELEASE,  8'h22, 32'd50,       32'd0,        1'b1);
    send_item(ACT_RELEASE,  8'h00, 32'd0,        32'd1,        1'b1);
    send_item(ACT_COMPLETE, 8'h21, 32'd0,        32'd1,        1'b1);
    send_item(ACT_COMPLETE, 8'h22, 32'd0,        32'd1,        1'b1);
    send_item(ACT_SPARE,    8'hFF, 32'hFFFFFFFF, 32'd2,        1'b1);
    send_item(ACT_RELEASE,  8'hFF, 32'hFFFFFFFF, 32'd2,        1'b1);
    send_item(ACT_TICK,     8'h00, 32'd0,        32'd101,      1'b1);
    send_item(ACT_TICK,     8'h00, 32'd0,        32'd101,      1'b1);
    send_item(ACT_RELEASE,  8'hA5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_item(ACT_TICK,     8'h00, 32'd0,        32'hFFFFFFFF, 1'b1);
    send_item(ACT_COMPLETE, 8'hFF, 32'd0,        32'hFFFFFFFF, 1'b1);
    send_item(ACT_COMPLETE, 8'hA5, 32'd0,        32'hFFFFFFFF, 1'b1);
    send_item(ACT_RELEASE,  8'h5A, 32'h55555555, 32'hAAAAAAAA, 1'b1);
    drain();

    // Random phases, one per threshold setting, each ending in a full drain
    foreach (cfg_plan[p]) begin
      apb_access(1'b1, {{(CFG_DW-EVENT_W){1'b0}}, cfg_plan[p]});
      apb_access(1'b0, '0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        @(negedge clk);
        pick_item(act, tid, dl, t_now);
        send_item(act, tid, dl, t_now, k >= 60 && k < 140);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d items under 6 dispatch thresholds, from 0 to 255, with random gaps.",
             n_items);
    $display("Predicted %0d dispatches, %0d preemptions, %0d completions, %0d overdue, %0d drops.",
             n_dispatch, n_preempt, n_done, n_late, n_drop);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
